// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define RGDD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define RGDD_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// File: design/rgdd_pkg.sv
// Package with the shared types, codes and defaults of the grant table block.
package rgdd_pkg;

    localparam int FIELD_BITS      = 16;
    localparam int KIND_BITS       = 2;
    localparam int PROCESS_ID_BITS = 3;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int MASK_BITS       = 8;

    localparam int DEF_PROCESSES      = 8;
    localparam int DEF_RESOURCE_TYPES = 4;
    localparam int DEF_AMOUNT_BITS    = 16;

    // Operation codes carried in the kind field of a request.
    typedef enum logic [KIND_BITS-1:0] {
        KIND_ADD     = 2'd0,
        KIND_GRANT   = 2'd1,
        KIND_RELEASE = 2'd2
    } kind_t;

    // Modes of the shared row unit.
    typedef enum logic [1:0] {
        MODE_ADD     = 2'd0,
        MODE_GRANT   = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_DETECT  = 2'd3
    } mode_t;

endpackage

// File: design/rgdd_in_if.sv
// Request channel interface: one operation on one process row.
interface rgdd_in_if import rgdd_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [KIND_BITS-1:0]       kind;
    logic [PROCESS_ID_BITS-1:0] process_id;
    logic [FIELD_BITS-1:0]      amount_0;
    logic [FIELD_BITS-1:0]      amount_1;
    logic [FIELD_BITS-1:0]      amount_2;
    logic [FIELD_BITS-1:0]      amount_3;

    modport source (
        output valid, kind, process_id, amount_0, amount_1, amount_2, amount_3,
        input  ready
    );
    modport sink (
        input  valid, kind, process_id, amount_0, amount_1, amount_2, amount_3,
        output ready
    );
endinterface

// File: design/rgdd_out_if.sv
// Response channel interface: success flag and deadlock mask.
interface rgdd_out_if import rgdd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 accepted;
    logic [MASK_BITS-1:0] deadlock_mask;

    modport source (
        output valid, accepted, deadlock_mask,
        input  ready
    );
    modport sink (
        input  valid, accepted, deadlock_mask,
        output ready
    );
endinterface

// File: design/rgdd_row_unit.sv
// Shared row unit: updates or checks one process row against a unit vector.
module rgdd_row_unit import rgdd_pkg::*; #(
    parameter int RESOURCE_TYPES = DEF_RESOURCE_TYPES,
    parameter int AMOUNT_BITS    = DEF_AMOUNT_BITS,
    parameter int WORK_BITS      = DEF_AMOUNT_BITS + 4
) (
    input  mode_t                                      mode,
    input  logic [RESOURCE_TYPES-1:0][AMOUNT_BITS-1:0] amount,
    input  logic [RESOURCE_TYPES-1:0][AMOUNT_BITS-1:0] pending,
    input  logic [RESOURCE_TYPES-1:0][AMOUNT_BITS-1:0] granted,
    input  logic [RESOURCE_TYPES-1:0][WORK_BITS-1:0]   vec_in,
    output logic                                       fits,
    output logic [RESOURCE_TYPES-1:0][AMOUNT_BITS-1:0] pending_out,
    output logic [RESOURCE_TYPES-1:0][AMOUNT_BITS-1:0] granted_out,
    output logic [RESOURCE_TYPES-1:0][WORK_BITS-1:0]   vec_out
);

    localparam logic [AMOUNT_BITS-1:0] AmtMax = '1;

    logic [RESOURCE_TYPES-1:0] lane_fit;

    // Each resource type is an independent lane; the mode picks the operation.
    always_comb
    begin
        logic [AMOUNT_BITS:0]   sum_p;
        logic [AMOUNT_BITS:0]   sum_g;
        logic [AMOUNT_BITS-1:0] give;
        logic [WORK_BITS-1:0]   wide_sum;
        pending_out = pending;
        granted_out = granted;
        vec_out     = vec_in;
        lane_fit    = '1;
        for (int t = 0; t < RESOURCE_TYPES; t++)
        begin
            sum_p    = {1'b0, pending[t]} + {1'b0, amount[t]};
            sum_g    = {1'b0, granted[t]} + {1'b0, pending[t]};
            give     = (amount[t] < granted[t]) ? amount[t] : granted[t];
            wide_sum = vec_in[t] + WORK_BITS'(give);
            unique case (mode)
                MODE_ADD:
                begin
                    pending_out[t] = sum_p[AMOUNT_BITS] ? AmtMax : sum_p[AMOUNT_BITS-1:0];
                end
                MODE_GRANT:
                begin
                    lane_fit[t]    = WORK_BITS'(pending[t]) <= vec_in[t];
                    vec_out[t]     = vec_in[t] - WORK_BITS'(pending[t]);
                    granted_out[t] = sum_g[AMOUNT_BITS] ? AmtMax : sum_g[AMOUNT_BITS-1:0];
                    pending_out[t] = '0;
                end
                MODE_RELEASE:
                begin
                    granted_out[t] = granted[t] - give;
                    vec_out[t]     = (wide_sum > WORK_BITS'(AmtMax)) ?
                                     WORK_BITS'(AmtMax) : wide_sum;
                end
                MODE_DETECT:
                begin
                    lane_fit[t] = WORK_BITS'(pending[t]) <= vec_in[t];
                    vec_out[t]  = vec_in[t] + WORK_BITS'(granted[t]);
                end
            endcase
        end
        fits = &lane_fit;
    end

endmodule

// File: design/resource_grant_deadlock_detect.sv
// Top level of the resource grant table with iterative deadlock detection.
//
// The block holds the free units of each resource type and, per process, the
// granted and pending units. Each request transaction adds to a pending row,
// grants a whole pending row if it fits in the free units, or releases granted
// units; a process_id at or above PROCESSES or an unused kind changes nothing
// and reports accepted = 0. Every request produces one response transaction
// with the success flag and a deadlock mask computed on the updated table.
// Flow: ST_IDLE takes the request, ST_OP applies the operation, ST_SCAN runs
// the detection scan and ST_DRAIN hands the result to the output register,
// waiting there while that register still holds a response not yet taken. The
// scan checks one process row per cycle through a single shared row unit and
// repeats full passes over all rows until a pass finishes no new process,
// making 1 to PROCESSES + 1 passes. The request side is ready only while
// the block is idle, but it does take a new request while an earlier
// response still waits in the output register.
// A configuration write with cfg_index i loads the free units
// of type i directly; writes are expected only while the block is idle.
// There is no clearing pass: all table state is cleared by reset.
`include "assert_macros.svh"

module resource_grant_deadlock_detect import rgdd_pkg::*; #(
    parameter int PROCESSES      = DEF_PROCESSES,
    parameter int RESOURCE_TYPES = DEF_RESOURCE_TYPES,
    parameter int AMOUNT_BITS    = DEF_AMOUNT_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [FIELD_BITS-1:0]     cfg_wdata,
    rgdd_in_if.sink                   req,
    rgdd_out_if.source                rsp
);

    // Row index width, and a work vector wide enough that summing the free
    // units and every granted row can never wrap.
    localparam int RowW      = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int WorkBits  = AMOUNT_BITS + $clog2(PROCESSES + 1);
    localparam int CopyW     = (AMOUNT_BITS < FIELD_BITS) ? AMOUNT_BITS : FIELD_BITS;

    typedef logic [RESOURCE_TYPES-1:0][AMOUNT_BITS-1:0] row_t;
    typedef logic [RESOURCE_TYPES-1:0][WorkBits-1:0]    work_t;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_OP    = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [RowW-1:0]         row_reg, row_next;
    work_t                   work_reg, work_next;
    logic [PROCESSES-1:0]    done_reg, done_next;
    logic                    moved_reg, moved_next;
    logic                    acc_reg, acc_next;
    logic                    op_ok_reg;
    logic [KIND_BITS-1:0]    kind_reg;
    row_t                    amt_reg;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_acc_reg;
    logic [MASK_BITS-1:0]    out_mask_reg;

    // Table storage. Rows are read only at row_reg; the holds bits track
    // whether each process owns any unit, so the mask needs no row sweep.
    row_t                    pending_reg [PROCESSES];
    row_t                    granted_reg [PROCESSES];
    logic [PROCESSES-1:0]    holds_reg;
    row_t                    free_reg;

    row_t                    req_amt;
    logic                    req_ok;
    logic [MASK_BITS-1:0]    mask_now;
    logic                    slot_free;
    logic                    table_wr;
    logic                    hit;
    logic                    last_row;

    mode_t                   unit_mode;
    work_t                   unit_vec_in;
    logic                    unit_fits;
    row_t                    unit_pending;
    row_t                    unit_granted;
    work_t                   unit_vec;

    // Amounts are masked to AMOUNT_BITS; types beyond RESOURCE_TYPES drop out.
    always_comb
    begin
        logic [FIELD_BITS-1:0] fields [4];
        logic [AMOUNT_BITS-1:0] amt;
        fields[0] = req.amount_0;
        fields[1] = req.amount_1;
        fields[2] = req.amount_2;
        fields[3] = req.amount_3;
        for (int t = 0; t < RESOURCE_TYPES; t++)
        begin
            amt             = '0;
            amt[CopyW-1:0]  = fields[t][CopyW-1:0];
            req_amt[t]      = amt;
        end
    end

    assign req_ok = ({1'b0, req.process_id} < (PROCESS_ID_BITS + 1)'(PROCESSES)) &&
                    (req.kind == KIND_ADD || req.kind == KIND_GRANT ||
                     req.kind == KIND_RELEASE);

    assign req.ready = (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || rsp.ready;

    // The shared unit applies the operation in ST_OP and checks one row per
    // cycle in ST_SCAN.
    always_comb
    begin
        if (state_reg == ST_OP)
        begin
            if (kind_reg == KIND_GRANT)
            begin
                unit_mode = MODE_GRANT;
            end
            else if (kind_reg == KIND_RELEASE)
            begin
                unit_mode = MODE_RELEASE;
            end
            else
            begin
                unit_mode = MODE_ADD;
            end
            for (int t = 0; t < RESOURCE_TYPES; t++)
            begin
                unit_vec_in[t] = WorkBits'(free_reg[t]);
            end
        end
        else
        begin
            unit_mode   = MODE_DETECT;
            unit_vec_in = work_reg;
        end
    end

    rgdd_row_unit #(
        .RESOURCE_TYPES (RESOURCE_TYPES),
        .AMOUNT_BITS    (AMOUNT_BITS),
        .WORK_BITS      (WorkBits)
    ) u_row_unit (
        .mode        (unit_mode),
        .amount      (amt_reg),
        .pending     (pending_reg[row_reg]),
        .granted     (granted_reg[row_reg]),
        .vec_in      (unit_vec_in),
        .fits        (unit_fits),
        .pending_out (unit_pending),
        .granted_out (unit_granted),
        .vec_out     (unit_vec)
    );

    // A valid operation writes the row back unless it is a grant that does
    // not fit in the free units.
    assign table_wr = op_ok_reg && (kind_reg != KIND_GRANT || unit_fits);
    assign hit      = !done_reg[row_reg] && unit_fits;
    assign last_row = (row_reg == RowW'(PROCESSES - 1));

    always_comb
    begin
        mask_now                  = '0;
        mask_now[PROCESSES-1:0]   = ~done_reg & holds_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        work_next      = work_reg;
        done_next      = done_reg;
        moved_next     = moved_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_OP;
                    row_next   = req.process_id[RowW-1:0];
                end
            end
            ST_OP:
            begin
                // The scan starts from the free units after the operation.
                acc_next   = table_wr;
                work_next  = table_wr ? unit_vec : unit_vec_in;
                done_next  = '0;
                moved_next = 1'b0;
                row_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    work_next          = unit_vec;
                    done_next[row_reg] = 1'b1;
                end
                if (last_row)
                begin
                    if (moved_reg || hit)
                    begin
                        row_next   = '0;
                        moved_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    moved_next = moved_reg || hit;
                end
            end
            ST_DRAIN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            done_reg      <= '0;
            moved_reg     <= 1'b0;
            acc_reg       <= 1'b0;
            op_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            done_reg      <= done_next;
            moved_reg     <= moved_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_IDLE && req.valid)
            begin
                op_ok_reg <= req_ok;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (state_reg == ST_IDLE && req.valid)
        begin
            kind_reg <= req.kind;
            amt_reg  <= req_amt;
        end
        if (state_reg == ST_DRAIN && slot_free)
        begin
            out_acc_reg  <= acc_reg;
            out_mask_reg <= mask_now;
        end
    end

    // Table state, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PROCESSES; p++)
            begin
                pending_reg[p] <= '0;
                granted_reg[p] <= '0;
            end
            holds_reg <= '0;
            free_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                for (int t = 0; t < RESOURCE_TYPES; t++)
                begin
                    if (cfg_index == CFG_INDEX_BITS'(t))
                    begin
                        free_reg[t] <= AMOUNT_BITS'(cfg_wdata[CopyW-1:0]);
                    end
                end
            end
            if (state_reg == ST_OP && table_wr)
            begin
                pending_reg[row_reg] <= unit_pending;
                granted_reg[row_reg] <= unit_granted;
                holds_reg[row_reg]   <= |unit_granted;
                for (int t = 0; t < RESOURCE_TYPES; t++)
                begin
                    free_reg[t] <= unit_vec[t][AMOUNT_BITS-1:0];
                end
            end
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.accepted      = out_acc_reg;
    assign rsp.deadlock_mask = out_mask_reg;

    // A rejected operation must never report success.
    `RGDD_ASSERT_NEXT(a_reject_not_accepted, state_reg == ST_OP && !op_ok_reg, !acc_reg,
        "rejected operation reported as accepted")

    // Finished processes stay finished for the rest of a scan.
    `RGDD_ASSERT(a_done_monotonic,
        (state_reg == ST_SCAN && $past(state_reg) == ST_SCAN) |->
            ((done_reg & $past(done_reg)) == $past(done_reg)),
        "finished process lost its done bit during the scan")

    // Leaving the drain state always presents a response.
    `RGDD_ASSERT_NEXT(a_drain_loads, state_reg == ST_DRAIN && slot_free, rsp.valid,
        "drained result not presented on the response channel")

    // The scan only runs with a row index inside the table.
    `RGDD_ASSERT(a_scan_row_range,
        (state_reg == ST_SCAN) |-> ({1'b0, row_reg} < (RowW + 1)'(PROCESSES)),
        "scan row index out of range")

endmodule
